### hdl/hsvc_pkg.sv
package hsvc_pkg;

    // Pipeline depth, one register stage per entry.
    localparam int NSTG = 6;

    localparam int PCT_W  = 7;
    localparam int CHAN_W = 8;
    localparam int HUE_W  = 16;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // Hue reduction: floor(hue / 360) = (hue * HUE_RECIP) >> HUE_SHIFT for any 16-bit hue.
    localparam int HUE_RECIP = 11651;
    localparam int HUE_SHIFT = 22;
    localparam int FULL_TURN = 360;

    // Level divisions, all of the form floor(num / den) with num = mult * x.
    // The estimate (x * recip) >> shift is at most one below the quotient.
    localparam int TOP_MULT  = 51;
    localparam int TOP_DEN   = 20;
    localparam int TOP_RECIP = 10444;
    localparam int TOP_SHIFT = 12;

    localparam int BOT_MULT  = 51;
    localparam int BOT_DEN   = 2000;
    localparam int BOT_RECIP = 26738;
    localparam int BOT_SHIFT = 20;

    localparam int MID_MULT  = 17;
    localparam int MID_DEN   = 40000;
    localparam int MID_RECIP = 7130;
    localparam int MID_SHIFT = 24;

    typedef enum logic [2:0] {
        SEC_0   = 3'd0,
        SEC_60  = 3'd1,
        SEC_120 = 3'd2,
        SEC_180 = 3'd3,
        SEC_240 = 3'd4,
        SEC_300 = 3'd5
    } t_sector;

    typedef struct packed {
        logic [NSTG-1:0] load;
        logic [NSTG-1:0] full;
    } t_pipe_ctl;

endpackage

### hdl/hsvc_pipe_ctrl.sv
module hsvc_pipe_ctrl import hsvc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    output t_pipe_ctl o_ctl
);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] w_en;

    // A stage may load when it is empty or when its own content moves on.
    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            w_en[i] = !r_vld[i] || w_en[i+1];
        end
        n_vld[0] = w_en[0] ? i_in_valid : r_vld[0];
        for (int i = 1; i < NSTG; i++) begin
            n_vld[i] = w_en[i] ? r_vld[i-1] : r_vld[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.load = w_en;
    assign o_ctl.full = r_vld;

endmodule

### hdl/hsv_to_rgb_converter.sv
// HSV to RGB color conversion; alpha is clamped to 100 and passed through.
// Throughput: one transaction per cycle while the output is not stalled.
// There are six register stages, each holding one item.
// A stall at the output backs up only as far as the stages that are full.
// Reset (synchronous, active low) clears the stage valid bits; data registers are not reset.
module hsv_to_rgb_converter import hsvc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // hue_degrees[15:0], saturation_pct, value_pct, alpha_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // red, green, blue, alpha_out[6:0], zero pad
);

    t_pipe_ctl w_ctl;

    hsvc_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_ctl       (w_ctl)
    );

    assign s_axis_tready = w_ctl.load[0];
    assign m_axis_tvalid = w_ctl.full[NSTG-1];

    // ---------------- Stage 1: clamps and hue quotient ----------------
    logic [HUE_W-1:0] w_hue_in;
    logic [7:0]       w_sat_in, w_val_in, w_alp_in;
    logic [29:0]      w_hue_prod;

    assign w_hue_in   = s_axis_tdata[15:0];
    assign w_sat_in   = s_axis_tdata[23:16];
    assign w_val_in   = s_axis_tdata[31:24];
    assign w_alp_in   = s_axis_tdata[39:32];
    assign w_hue_prod = 30'(w_hue_in) * 30'(HUE_RECIP);

    logic [HUE_W-1:0] r_hue1;
    logic [7:0]       r_q1;
    logic [PCT_W-1:0] r_sat1, r_val1, r_alp1;

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[0]) begin
            r_hue1 <= w_hue_in;
            r_q1   <= w_hue_prod[HUE_SHIFT+7:HUE_SHIFT];
            r_sat1 <= (w_sat_in > 8'(PCT_MAX)) ? PCT_MAX : w_sat_in[PCT_W-1:0];
            r_val1 <= (w_val_in > 8'(PCT_MAX)) ? PCT_MAX : w_val_in[PCT_W-1:0];
            r_alp1 <= (w_alp_in > 8'(PCT_MAX)) ? PCT_MAX : w_alp_in[PCT_W-1:0];
        end
    end

    // ---------------- Stage 2: reduced hue and S*V ----------------
    logic [HUE_W-1:0] w_h_full;
    assign w_h_full = r_hue1 - 16'(r_q1) * 16'(FULL_TURN);

    logic [8:0]       r_h2;
    logic [13:0]      r_sv2;
    logic [PCT_W-1:0] r_val2, r_alp2;

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[1]) begin
            r_h2   <= w_h_full[8:0];
            r_sv2  <= 14'(r_sat1) * 14'(r_val1);
            r_val2 <= r_val1;
            r_alp2 <= r_alp1;
        end
    end

    // ---------------- Stage 3: sector, k and partial numerators ----------------
    t_sector    n_sec3;
    logic [8:0] w_r120_full;
    logic [6:0] w_r120;
    logic [5:0] n_k3;

    always_comb begin
        if (r_h2 < 9'd60) begin
            n_sec3 = SEC_0;
        end else if (r_h2 < 9'd120) begin
            n_sec3 = SEC_60;
        end else if (r_h2 < 9'd180) begin
            n_sec3 = SEC_120;
        end else if (r_h2 < 9'd240) begin
            n_sec3 = SEC_180;
        end else if (r_h2 < 9'd300) begin
            n_sec3 = SEC_240;
        end else begin
            n_sec3 = SEC_300;
        end
        if (r_h2 >= 9'd240) begin
            w_r120_full = r_h2 - 9'd240;
        end else if (r_h2 >= 9'd120) begin
            w_r120_full = r_h2 - 9'd120;
        end else begin
            w_r120_full = r_h2;
        end
        w_r120 = w_r120_full[6:0];
        // k = 60 - |r120 - 60| rises over the first half and falls over the second.
        if (w_r120 < 7'd60) begin
            n_k3 = w_r120[5:0];
        end else begin
            n_k3 = 6'(7'd120 - w_r120);
        end
    end

    t_sector          r_sec3;
    logic [5:0]       r_k3;
    logic [19:0]      r_base3;
    logic [13:0]      r_sv3, r_b3;
    logic [PCT_W-1:0] r_val3, r_alp3;

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[2]) begin
            r_sec3  <= n_sec3;
            r_k3    <= n_k3;
            r_base3 <= 20'(r_val2) * 20'd6000 - 20'(r_sv2) * 20'd60;
            r_sv3   <= r_sv2;
            r_b3    <= 14'(r_val2) * 14'd100 - r_sv2;
            r_val3  <= r_val2;
            r_alp3  <= r_alp2;
        end
    end

    // ---------------- Stage 4: middle numerator ----------------
    t_sector          r_sec4;
    logic [19:0]      r_t4;
    logic [13:0]      r_b4;
    logic [PCT_W-1:0] r_val4, r_alp4;

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[3]) begin
            r_sec4 <= r_sec3;
            r_t4   <= r_base3 + 20'(r_sv3) * 20'(r_k3);
            r_b4   <= r_b3;
            r_val4 <= r_val3;
            r_alp4 <= r_alp3;
        end
    end

    // ---------------- Stage 5: reciprocal quotient estimates ----------------
    logic [32:0] w_mid_prod;
    logic [28:0] w_bot_prod;
    logic [20:0] w_top_prod;

    assign w_mid_prod = 33'(r_t4) * 33'(MID_RECIP);
    assign w_bot_prod = 29'(r_b4) * 29'(BOT_RECIP);
    assign w_top_prod = 21'(r_val4) * 21'(TOP_RECIP);

    t_sector           r_sec5;
    logic [CHAN_W-1:0] r_em5, r_eb5, r_et5;
    logic [19:0]       r_t5;
    logic [13:0]       r_b5;
    logic [PCT_W-1:0]  r_val5, r_alp5;

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[4]) begin
            r_sec5 <= r_sec4;
            r_em5  <= w_mid_prod[MID_SHIFT+7:MID_SHIFT];
            r_eb5  <= w_bot_prod[BOT_SHIFT+7:BOT_SHIFT];
            r_et5  <= w_top_prod[TOP_SHIFT+7:TOP_SHIFT];
            r_t5   <= r_t4;
            r_b5   <= r_b4;
            r_val5 <= r_val4;
            r_alp5 <= r_alp4;
        end
    end

    // ---------------- Stage 6: quotient correction and channel assignment ----------------
    logic [24:0]       w_mid_rem;
    logic [19:0]       w_bot_rem;
    logic [12:0]       w_top_rem;
    logic [CHAN_W-1:0] w_mid, w_bot, w_top;
    logic [CHAN_W-1:0] n_red6, n_grn6, n_blu6;

    // Each estimate is never above the true quotient, so the remainder is never negative.
    assign w_mid_rem = 25'(r_t5) * 25'(MID_MULT) - 25'(r_em5) * 25'(MID_DEN);
    assign w_bot_rem = 20'(r_b5) * 20'(BOT_MULT) - 20'(r_eb5) * 20'(BOT_DEN);
    assign w_top_rem = 13'(r_val5) * 13'(TOP_MULT) - 13'(r_et5) * 13'(TOP_DEN);

    assign w_mid = r_em5 + 8'(w_mid_rem >= 25'(MID_DEN));
    assign w_bot = r_eb5 + 8'(w_bot_rem >= 20'(BOT_DEN));
    assign w_top = r_et5 + 8'(w_top_rem >= 13'(TOP_DEN));

    always_comb begin
        case (r_sec5)
            SEC_0: begin
                n_red6 = w_top; n_grn6 = w_mid; n_blu6 = w_bot;
            end
            SEC_60: begin
                n_red6 = w_mid; n_grn6 = w_top; n_blu6 = w_bot;
            end
            SEC_120: begin
                n_red6 = w_bot; n_grn6 = w_top; n_blu6 = w_mid;
            end
            SEC_180: begin
                n_red6 = w_bot; n_grn6 = w_mid; n_blu6 = w_top;
            end
            SEC_240: begin
                n_red6 = w_mid; n_grn6 = w_bot; n_blu6 = w_top;
            end
            SEC_300: begin
                n_red6 = w_top; n_grn6 = w_bot; n_blu6 = w_mid;
            end
            default: begin
                n_red6 = w_top; n_grn6 = w_mid; n_blu6 = w_bot;
            end
        endcase
    end

    logic [CHAN_W-1:0] r_red6, r_grn6, r_blu6;
    logic [PCT_W-1:0]  r_alp6;

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[5]) begin
            r_red6 <= n_red6;
            r_grn6 <= n_grn6;
            r_blu6 <= n_blu6;
            r_alp6 <= r_alp5;
        end
    end

    assign m_axis_tdata = {1'b0, r_alp6, r_blu6, r_grn6, r_red6};

    // ---------------- Assertions ----------------
    a_hue_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.full[1] |-> (r_h2 < 9'd360))
        else $error("reduced hue out of range");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.full[2] |-> (r_k3 <= 6'd60))
        else $error("sector ramp k above 60");

    a_alpha_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_alp6 <= PCT_MAX))
        else $error("alpha out of range at output");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&w_ctl.full) && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while every stage is full and stalled");

endmodule
